/* src/dtq_pkg.sv */
`default_nettype none
package dtq_pkg;

	localparam int unsigned N_TIMERS = 16;
	localparam int unsigned ID_W     = 4;
	localparam int unsigned LEN_W    = 5;
	localparam int unsigned DELTA_W  = 32;
	localparam int unsigned OWN_W    = 16;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_TICK   = 2'd2,
		CMD_UNUSED = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_ACCEPTED  = 2'd0,
		KIND_EXPIRED   = 2'd1,
		KIND_REJECTED  = 2'd2,
		KIND_IDLE_TICK = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RESP,
		ST_ADD_RD,
		ST_ADD_CHK,
		ST_ADD_WCUR,
		ST_ADD_WNEW,
		ST_ADD_WPREV,
		ST_DEL_RD,
		ST_DEL_CHK,
		ST_DEL_RDS,
		ST_DEL_WSUC,
		ST_DEL_WPREV,
		ST_TK_PEEK,
		ST_TK_CHK,
		ST_TK_LOOK,
		ST_TK_EMIT
	} state_t;

	// one read and one write per cycle on the slot store
	typedef struct packed {
		logic               rd_en;
		logic [ID_W-1:0]    rd_addr;
		logic               wr_en;
		logic [ID_W-1:0]    wr_addr;
		logic [ID_W-1:0]    wr_next;
		logic [DELTA_W-1:0] wr_delta;
		logic               own_we;
		logic [OWN_W-1:0]   own_data;
	} mem_req_t;

	typedef struct packed {
		logic [ID_W-1:0]    next;
		logic [DELTA_W-1:0] delta;
		logic [OWN_W-1:0]   owner;
	} mem_rsp_t;

endpackage
`default_nettype wire

/* src/dtq_store.sv */
`default_nettype none
module dtq_store (
	input  wire logic              clk,
	input  wire dtq_pkg::mem_req_t req,
	output dtq_pkg::mem_rsp_t      rsp
);
	// link and delta share one word; owner sits in its own array
	logic [dtq_pkg::ID_W+dtq_pkg::DELTA_W-1:0] link_mem [dtq_pkg::N_TIMERS];
	logic [dtq_pkg::OWN_W-1:0]                 own_mem  [dtq_pkg::N_TIMERS];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			link_mem[req.wr_addr] <= {req.wr_next, req.wr_delta};
		end
		if (req.own_we) begin
			own_mem[req.wr_addr] <= req.own_data;
		end
		if (req.rd_en) begin
			{rsp.next, rsp.delta} <= link_mem[req.rd_addr];
			rsp.owner             <= own_mem[req.rd_addr];
		end
	end
endmodule
`default_nettype wire

/* src/delta_timer_queue.sv */
`default_nettype none
// Delta-list timer queue for up to 16 numbered timers.
// Slave stream carries commands: tuser = cmd (0 add, 1 delete, 2 tick),
// tdata = timer_id, delay, owner. Master stream carries results:
// tuser = kind, tdata = id and owner, tlast marks the final result of a command.
// Add and delete give one result; a tick gives one result per expired timer,
// or one idle-tick result.
// Timers live in a linked list in a slot store with registered reads;
// each entry keeps its delay relative to its predecessor.
// Commands walk the list over the store's single read port, so one
// command is in work at a time and up to 16 entries may be visited.
// A command is taken whenever the engine is idle, even while the last result
// still waits in the output register; a stalled receiver holds the engine at
// its next result until the register frees.
// Reset empties the list and disarms all timers; store contents are left
// as they are and only read for armed slots.
module delta_timer_queue (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,  // [3:0] timer_id, [35:4] delay, [51:36] owner, zero pad
	input  wire logic [1:0]  s_tuser,  // [1:0] cmd
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,  // [3:0] expired or command timer_id, [19:4] expired_owner, zero pad
	output logic [1:0]       m_tuser,  // [1:0] kind
	output logic             m_tlast
);
	localparam int unsigned IW = dtq_pkg::ID_W;
	localparam int unsigned LW = dtq_pkg::LEN_W;
	localparam int unsigned DW = dtq_pkg::DELTA_W;
	localparam int unsigned OW = dtq_pkg::OWN_W;

	dtq_pkg::state_t   state_q, state_d;
	dtq_pkg::mem_req_t req;
	dtq_pkg::mem_rsp_t rsp;

	logic [IW-1:0]               head_q, id_q, cur_q, prev_q, nxt_q, pend_id_q, res_id_q;
	logic [LW-1:0]               len_q, cnt_q;
	logic [dtq_pkg::N_TIMERS-1:0] armed_q;
	logic [DW-1:0]               rem_q, prev_d_q, del_d_q;
	logic [OW-1:0]               own_q, pend_own_q;
	logic                        has_prev_q, first_q, final_q;
	dtq_pkg::kind_t              res_kind_q;

	// input fields
	dtq_pkg::cmd_t in_cmd;
	logic [IW-1:0] in_id;
	logic [DW-1:0] in_delay;
	logic [OW-1:0] in_owner;
	logic          in_acc, out_load;
	logic [DW-1:0] dn;     // head delta after this tick's decrement
	logic          hit;

	assign in_cmd   = dtq_pkg::cmd_t'(s_tuser);
	assign in_id    = s_tdata[3:0];
	assign in_delay = s_tdata[35:4];
	assign in_owner = s_tdata[51:36];
	assign s_tready = (state_q == dtq_pkg::ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_load = ((state_q == dtq_pkg::ST_RESP) || (state_q == dtq_pkg::ST_TK_EMIT))
		&& (!m_tvalid || m_tready);
	assign dn       = (first_q && (rsp.delta != '0)) ? rsp.delta - 1'b1 : rsp.delta;
	assign hit      = (rem_q < rsp.delta);

	dtq_store u_store (
		.clk (clk),
		.req (req),
		.rsp (rsp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dtq_pkg::ST_IDLE: begin
				if (in_acc) begin
					unique case (in_cmd)
						dtq_pkg::CMD_ADD: begin
							if (in_delay == '0 || armed_q[in_id]) state_d = dtq_pkg::ST_RESP;
							else state_d = dtq_pkg::ST_ADD_RD;
						end
						dtq_pkg::CMD_DELETE: begin
							if (!armed_q[in_id]) state_d = dtq_pkg::ST_RESP;
							else state_d = dtq_pkg::ST_DEL_RD;
						end
						dtq_pkg::CMD_TICK: begin
							if (len_q == '0) state_d = dtq_pkg::ST_RESP;
							else state_d = dtq_pkg::ST_TK_PEEK;
						end
						default: state_d = dtq_pkg::ST_RESP;
					endcase
				end
			end
			dtq_pkg::ST_RESP:     if (out_load) state_d = dtq_pkg::ST_IDLE;
			dtq_pkg::ST_ADD_RD:   state_d = (cnt_q == '0) ? dtq_pkg::ST_ADD_WNEW : dtq_pkg::ST_ADD_CHK;
			dtq_pkg::ST_ADD_CHK:  state_d = hit ? dtq_pkg::ST_ADD_WCUR : dtq_pkg::ST_ADD_RD;
			dtq_pkg::ST_ADD_WCUR: state_d = dtq_pkg::ST_ADD_WNEW;
			dtq_pkg::ST_ADD_WNEW: state_d = has_prev_q ? dtq_pkg::ST_ADD_WPREV : dtq_pkg::ST_RESP;
			dtq_pkg::ST_ADD_WPREV: state_d = dtq_pkg::ST_RESP;
			dtq_pkg::ST_DEL_RD:   state_d = dtq_pkg::ST_DEL_CHK;
			dtq_pkg::ST_DEL_CHK: begin
				if (cur_q != id_q) state_d = dtq_pkg::ST_DEL_RD;
				else if (cnt_q > LW'(1)) state_d = dtq_pkg::ST_DEL_RDS;
				else state_d = dtq_pkg::ST_DEL_WPREV;
			end
			dtq_pkg::ST_DEL_RDS:   state_d = dtq_pkg::ST_DEL_WSUC;
			dtq_pkg::ST_DEL_WSUC:  state_d = dtq_pkg::ST_DEL_WPREV;
			dtq_pkg::ST_DEL_WPREV: state_d = dtq_pkg::ST_RESP;
			dtq_pkg::ST_TK_PEEK:   state_d = first_q ? dtq_pkg::ST_TK_CHK : dtq_pkg::ST_TK_LOOK;
			dtq_pkg::ST_TK_CHK: begin
				if (dn != '0) state_d = dtq_pkg::ST_RESP;
				else if (len_q == LW'(1)) state_d = dtq_pkg::ST_TK_EMIT;
				else state_d = dtq_pkg::ST_TK_PEEK;
			end
			dtq_pkg::ST_TK_LOOK: state_d = dtq_pkg::ST_TK_EMIT;
			dtq_pkg::ST_TK_EMIT: begin
				if (out_load) state_d = final_q ? dtq_pkg::ST_IDLE : dtq_pkg::ST_TK_CHK;
			end
			default: state_d = dtq_pkg::ST_IDLE;
		endcase
	end

	// store requests
	always_comb begin
		req          = '0;
		req.own_data = own_q;
		unique case (state_q)
			dtq_pkg::ST_ADD_RD: begin
				req.rd_en   = (cnt_q != '0);
				req.rd_addr = cur_q;
			end
			dtq_pkg::ST_ADD_WCUR: begin
				req.wr_en    = 1'b1;
				req.wr_addr  = cur_q;
				req.wr_next  = rsp.next;
				req.wr_delta = rsp.delta - rem_q;
			end
			dtq_pkg::ST_ADD_WNEW: begin
				req.wr_en    = 1'b1;
				req.own_we   = 1'b1;
				req.wr_addr  = id_q;
				req.wr_next  = cur_q;
				req.wr_delta = rem_q;
			end
			dtq_pkg::ST_ADD_WPREV: begin
				req.wr_en    = 1'b1;
				req.wr_addr  = prev_q;
				req.wr_next  = id_q;
				req.wr_delta = prev_d_q;
			end
			dtq_pkg::ST_DEL_RD: begin
				req.rd_en   = 1'b1;
				req.rd_addr = cur_q;
			end
			dtq_pkg::ST_DEL_RDS: begin
				req.rd_en   = 1'b1;
				req.rd_addr = nxt_q;
			end
			dtq_pkg::ST_DEL_WSUC: begin
				req.wr_en    = 1'b1;
				req.wr_addr  = nxt_q;
				req.wr_next  = rsp.next;
				req.wr_delta = rsp.delta + del_d_q;
			end
			dtq_pkg::ST_DEL_WPREV: begin
				req.wr_en    = has_prev_q;
				req.wr_addr  = prev_q;
				req.wr_next  = nxt_q;
				req.wr_delta = prev_d_q;
			end
			dtq_pkg::ST_TK_PEEK: begin
				req.rd_en   = 1'b1;
				req.rd_addr = head_q;
			end
			dtq_pkg::ST_TK_CHK: begin
				// surviving head keeps its decremented delta
				req.wr_en    = (dn != '0) && (dn != rsp.delta);
				req.wr_addr  = head_q;
				req.wr_next  = rsp.next;
				req.wr_delta = dn;
			end
			default: req.rd_en = 1'b0;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= dtq_pkg::ST_IDLE;
			len_q    <= '0;
			armed_q  <= '0;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
			if (state_q == dtq_pkg::ST_ADD_WNEW) begin
				len_q          <= len_q + 1'b1;
				armed_q[id_q]  <= 1'b1;
			end
			if (state_q == dtq_pkg::ST_DEL_WPREV) begin
				len_q          <= len_q - 1'b1;
				armed_q[id_q]  <= 1'b0;
			end
			if (state_q == dtq_pkg::ST_TK_CHK && dn == '0) begin
				len_q            <= len_q - 1'b1;
				armed_q[head_q]  <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			dtq_pkg::ST_IDLE: begin
				id_q       <= in_id;
				rem_q      <= in_delay;
				own_q      <= in_owner;
				cur_q      <= head_q;
				cnt_q      <= len_q;
				has_prev_q <= 1'b0;
				first_q    <= 1'b1;
				res_id_q   <= (in_cmd == dtq_pkg::CMD_TICK) ? '0 : in_id;
				unique case (in_cmd)
					dtq_pkg::CMD_ADD:    res_kind_q <= dtq_pkg::KIND_REJECTED;
					dtq_pkg::CMD_DELETE: res_kind_q <= dtq_pkg::KIND_ACCEPTED;
					dtq_pkg::CMD_TICK:   res_kind_q <= dtq_pkg::KIND_IDLE_TICK;
					default: res_kind_q <= dtq_pkg::KIND_REJECTED;
				endcase
			end
			dtq_pkg::ST_ADD_CHK: begin
				if (!hit) begin
					rem_q      <= rem_q - rsp.delta;
					prev_q     <= cur_q;
					prev_d_q   <= rsp.delta;
					has_prev_q <= 1'b1;
					cur_q      <= rsp.next;
					cnt_q      <= cnt_q - 1'b1;
				end
			end
			dtq_pkg::ST_ADD_WNEW: begin
				res_kind_q <= dtq_pkg::KIND_ACCEPTED;
				if (!has_prev_q) head_q <= id_q;
			end
			dtq_pkg::ST_DEL_CHK: begin
				if (cur_q == id_q) begin
					del_d_q <= rsp.delta;
					nxt_q   <= rsp.next;
				end else begin
					prev_q     <= cur_q;
					prev_d_q   <= rsp.delta;
					has_prev_q <= 1'b1;
					cur_q      <= rsp.next;
					cnt_q      <= cnt_q - 1'b1;
				end
			end
			dtq_pkg::ST_DEL_WPREV: begin
				if (!has_prev_q) head_q <= nxt_q;
			end
			dtq_pkg::ST_TK_CHK: begin
				if (dn == '0) begin
					pend_id_q  <= head_q;
					pend_own_q <= rsp.owner;
					head_q     <= rsp.next;
					first_q    <= 1'b0;
					final_q    <= (len_q == LW'(1));
				end
			end
			dtq_pkg::ST_TK_LOOK: final_q <= (rsp.delta != '0);
			default: first_q <= first_q;
		endcase

		if (out_load) begin
			if (state_q == dtq_pkg::ST_RESP) begin
				m_tuser <= res_kind_q;
				m_tdata <= {4'd0, {OW{1'b0}}, res_id_q};
				m_tlast <= 1'b1;
			end else begin
				m_tuser <= dtq_pkg::KIND_EXPIRED;
				m_tdata <= {4'd0, pend_own_q, pend_id_q};
				m_tlast <= final_q;
			end
		end
	end
endmodule
`default_nettype wire
